[hw/rtl/pdm_pkg.sv]
package pdm_pkg;

  // Event kinds carried on the input tuser
  localparam logic CMD_CAPTURE  = 1'b0;
  localparam logic CMD_OVERFLOW = 1'b1;

  localparam int unsigned CNT_FIELD_W = 32;
  localparam int unsigned DUTY_W      = 7;

  // Divider sizes: the duty numerator is pulse*100 + period/2, which fits in 40 bits
  localparam int unsigned DIV_W     = 40;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  // Output tdata layout, lowest bit first
  localparam int unsigned OUT_DATA_W = 5 * CNT_FIELD_W + DUTY_W + 1;

  localparam logic [CNT_FIELD_W-1:0] CLOCK_RESET = 32'd1000000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FREQ,
    ST_DUTY,
    ST_OUT
  } pdm_state_e;

  typedef struct packed {
    logic                   start;
    logic [DIV_W-1:0]       dividend;
    logic [CNT_FIELD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

[hw/rtl/pwm_period_duty_meter_core.sv]
// Channel   | Direction | Signals                  | Contents
// s_axis    | in        | tvalid tready tdata tuser | period, pulse; tuser = event kind
// m_axis    | out       | tvalid tready tdata tuser | state snapshot; tuser = accepted
// cfg       | in        | valid ready data         | capture counter clock in hertz
//
// A valid capture is accepted, runs two 40-step divisions on the shared
// bit-serial divider (frequency, then duty), then the handoff and output.
// Overflow events and rejected captures skip the divider and go to the handoff.
// Reset clears all measurement state and loads the counter clock with 1 MHz.
// The result sits in an output register; a stalled output holds the sequencer
// before the handoff, so the next input is only accepted after the handoff.
module pwm_period_duty_meter_core
  import pdm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // cfg
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CNT_FIELD_W-1:0] cfg_data_i,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] period_count, [63:32] pulse_count
  input  logic [63:0]            s_axis_tdata,
  // [0] cmd
  input  logic                   s_axis_tuser,
  // output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [31:0] period_out, [63:32] pulse_out, [95:64] frequency, [102:96] duty,
  // [134:103] edges_seen, [166:135] overflows_seen, [167] detected
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  // [0] accepted
  output logic                   m_axis_tuser
);

  pdm_state_e state_q, state_d;

  logic [CNT_FIELD_W-1:0] counter_clock_q;
  logic [CNT_FIELD_W-1:0] period_q, pulse_q, freq_q, edges_q, ovfs_q;
  logic [DUTY_W-1:0]      duty_q;
  logic                   detected_q;
  logic                   acc_q;

  logic [CNT_FIELD_W-1:0] op_period_q, op_pulse_q, freq_res_q;
  logic [DIV_W-1:0]       num_q;

  logic                   out_valid_q;
  logic [OUT_DATA_W-1:0]  out_data_q;
  logic                   out_user_q;

  logic [CNT_FIELD_W-1:0] in_period, in_pulse;
  logic                   in_fire, cap_ok, out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_period = s_axis_tdata[CNT_FIELD_W-1:0];
  assign in_pulse  = s_axis_tdata[2*CNT_FIELD_W-1:CNT_FIELD_W];
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign cap_ok    = (in_period != '0) && (in_pulse <= in_period);
  assign out_free  = !out_valid_q || m_axis_tready;

  pdm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer: frequency then duty division if valid capture, then handoff
  always_comb begin
    state_d          = state_q;
    s_axis_tready    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {{(DIV_W-CNT_FIELD_W){1'b0}}, counter_clock_q};
    div_req.divisor  = in_period;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser == CMD_CAPTURE && cap_ok) begin
            div_req.start = 1'b1;
            state_d       = ST_FREQ;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_FREQ: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = num_q;
          div_req.divisor  = op_period_q;
          state_d          = ST_DUTY;
        end
      end
      ST_DUTY: begin
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration register, written only while idle and no input is offered
  assign cfg_ready_o = (state_q == ST_IDLE) && !s_axis_tvalid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_clock_q <= CLOCK_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      counter_clock_q <= cfg_data_i;
    end
  end

  // Measurement state: overflow on accept, capture commit at duty done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= '0;
      pulse_q    <= '0;
      freq_q     <= '0;
      duty_q     <= '0;
      edges_q    <= '0;
      ovfs_q     <= '0;
      detected_q <= 1'b0;
      acc_q      <= 1'b0;
    end else begin
      if (state_q == ST_IDLE && in_fire) begin
        acc_q <= 1'b0;
        if (s_axis_tuser == CMD_OVERFLOW) begin
          ovfs_q     <= ovfs_q + 1'b1;
          detected_q <= 1'b0;
          freq_q     <= '0;
          duty_q     <= '0;
        end
      end
      if (state_q == ST_DUTY && div_rsp.done) begin
        period_q   <= op_period_q;
        pulse_q    <= op_pulse_q;
        freq_q     <= freq_res_q;
        duty_q     <= div_rsp.quotient[DUTY_W-1:0];
        edges_q    <= edges_q + 1'b1;
        detected_q <= 1'b1;
        acc_q      <= 1'b1;
      end
    end
  end

  // Operands of the running capture and the duty numerator
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_fire) begin
      op_period_q <= in_period;
      op_pulse_q  <= in_pulse;
    end
    // pulse*100 + period/2 as shifted adds
    num_q <= {2'b00, op_pulse_q, 6'b0} + {3'b000, op_pulse_q, 5'b0}
           + {6'b0, op_pulse_q, 2'b00} + {9'b0, op_period_q[CNT_FIELD_W-1:1]};
    if (state_q == ST_FREQ && div_rsp.done) begin
      freq_res_q <= div_rsp.quotient[CNT_FIELD_W-1:0];
    end
  end

  // Output register: load the snapshot, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      out_data_q <= {detected_q, ovfs_q, edges_q, duty_q, freq_q, pulse_q, period_q};
      out_user_q <= acc_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUTY && div_rsp.done |-> div_rsp.quotient <= DIV_W'(100))
    else $error("duty quotient above 100 percent");

  a_nonzero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FREQ || state_q == ST_DUTY |-> op_period_q != '0)
    else $error("division by a zero period");

  a_accept_detects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[OUT_DATA_W-1])
    else $error("accepted capture without detected flag");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> state_q == ST_FREQ || state_q == ST_DUTY)
    else $error("divider running outside a division state");

endmodule

[hw/rtl/pdm_div.sv]
module pdm_div
  import pdm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [CNT_FIELD_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0]       quo_q, quo_d;
  logic [CNT_FIELD_W-1:0] dvs_q;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;

  logic [CNT_FIELD_W:0]   shifted;
  logic [CNT_FIELD_W+1:0] diff;
  logic                   ge;

  // One restoring step: shift in the next dividend bit, trial subtract
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = ~diff[CNT_FIELD_W+1];

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      cnt_d  = DIV_CNT_W'(DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[CNT_FIELD_W-1:0] : shifted[CNT_FIELD_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider finished without running");

  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start)
    else $error("divider started while busy");

  a_remainder_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (dvs_q != '0) |-> rem_q < dvs_q)
    else $error("partial remainder reached the divisor");

endmodule
